[src/chip8_pkg.sv]
// ----------------------------------------------------------------------------
// chip8_pkg
// shared constants, command and status codes, font glyphs for the chip-8 core
// ----------------------------------------------------------------------------
package chip8_pkg;

  // default sizes
  localparam int unsigned MEM_BYTES_DEF     = 4096;
  localparam int unsigned STACK_DEPTH_DEF   = 16;
  localparam int unsigned SCREEN_WIDTH_DEF  = 64;
  localparam int unsigned SCREEN_HEIGHT_DEF = 32;
  localparam int unsigned PROGRAM_START_DEF = 512;

  // fixed field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned PC_W     = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KEYS_W   = 16;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned ROW_W    = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NREGS    = 16;
  localparam int unsigned VIDX_W   = 4;

  // font placement
  localparam int unsigned FONT_BASE  = 'h50;
  localparam int unsigned FONT_BYTES = 80;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXEC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROW  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BADOP = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd3;

  // opcode low-byte selectors
  localparam logic [7:0] NN_CLS  = 8'hE0;
  localparam logic [7:0] NN_RET  = 8'hEE;
  localparam logic [7:0] NN_SKP  = 8'h9E;
  localparam logic [7:0] NN_SKNP = 8'hA1;
  localparam logic [7:0] NN_GDT  = 8'h07;
  localparam logic [7:0] NN_KEY  = 8'h0A;
  localparam logic [7:0] NN_SDT  = 8'h15;
  localparam logic [7:0] NN_SST  = 8'h18;
  localparam logic [7:0] NN_ADDI = 8'h1E;
  localparam logic [7:0] NN_FONT = 8'h29;
  localparam logic [7:0] NN_BCD  = 8'h33;
  localparam logic [7:0] NN_STR  = 8'h55;
  localparam logic [7:0] NN_LDR  = 8'h65;

  localparam logic [3:0] VF_IDX = 4'hF;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] b;
    case (idx)
      7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22,
      7'd25, 7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40,
      7'd42, 7'd44, 7'd45, 7'd47, 7'd49, 7'd50, 7'd52, 7'd57,
      7'd70, 7'd72, 7'd74, 7'd75, 7'd77: b = 8'hF0;
      7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46,
      7'd51, 7'd53, 7'd54, 7'd56, 7'd58, 7'd61, 7'd63, 7'd66, 7'd67,
      7'd68: b = 8'h90;
      7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
      7'd6, 7'd60, 7'd64: b = 8'h60;
      7'd9: b = 8'h70;
      7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
      7'd13, 7'd26, 7'd31, 7'd62, 7'd71, 7'd73, 7'd76, 7'd78,
      7'd79: b = 8'h80;
      7'd38, 7'd39: b = 8'h40;
      7'd55, 7'd59, 7'd65, 7'd69: b = 8'hE0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [VIDX_W-1:0] lowest_key(input logic [KEYS_W-1:0] k);
    logic [VIDX_W-1:0] r;
    r = '0;
    for (int i = KEYS_W - 1; i >= 0; i--) begin
      if (k[i]) r = VIDX_W'(i);
    end
    return r;
  endfunction

endpackage

[src/chip8_interpreter_core.sv]
// ----------------------------------------------------------------------------
// chip8_interpreter_core
// chip-8 interpreter: memory load/read, single-step execute, timer tick,
// screen row readout
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  in       | in_valid_i / in_ready_o  | cmd, address, data, keys, random_byte
//  out      | out_valid_o / out_ready_i| program_counter, read_data, status,
//           |                          | sound_on, waiting_key
//
// a byte read goes through the memory read state; execute fetches the
// opcode, reads the registers, runs it, then may write Vx and VF; DXYN loops
// per sprite row, FX55/FX65 per register, FX33 per digit; loops go
// through the single memory port
// after reset a clearing pass writes zero and the font into memory, one byte
// per cycle, with in_ready_o low
// a finished item waits in the output register; the core takes the next item
// meanwhile and only holds its own completion while the output is stalled
// ----------------------------------------------------------------------------
module chip8_interpreter_core #(
  parameter int unsigned MEM_BYTES     = chip8_pkg::MEM_BYTES_DEF,
  parameter int unsigned STACK_DEPTH   = chip8_pkg::STACK_DEPTH_DEF,
  parameter int unsigned SCREEN_WIDTH  = chip8_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = chip8_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned PROGRAM_START = chip8_pkg::PROGRAM_START_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [chip8_pkg::CMD_W-1:0]       cmd_i,
  input  logic [chip8_pkg::ADDR_W-1:0]      address_i,
  input  logic [chip8_pkg::BYTE_W-1:0]      data_i,
  input  logic [chip8_pkg::KEYS_W-1:0]      keys_i,
  input  logic [chip8_pkg::BYTE_W-1:0]      random_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [chip8_pkg::PC_W-1:0]        program_counter_o,
  output logic [chip8_pkg::ROW_W-1:0]       read_data_o,
  output logic [chip8_pkg::STATUS_W-1:0]    status_o,
  output logic                              sound_on_o,
  output logic                              waiting_key_o
);

  import chip8_pkg::*;

  localparam int unsigned AW  = $clog2(MEM_BYTES);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SPI = $clog2(STACK_DEPTH);
  localparam int unsigned HW  = $clog2(SCREEN_HEIGHT);
  localparam int unsigned XW  = $clog2(SCREEN_WIDTH);
  localparam int unsigned SW  = SCREEN_WIDTH;

  // sequencer codes
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_MRD   = 5'd2;
  localparam logic [4:0] S_F1    = 5'd3;
  localparam logic [4:0] S_F2    = 5'd4;
  localparam logic [4:0] S_F3    = 5'd5;
  localparam logic [4:0] S_RX    = 5'd6;
  localparam logic [4:0] S_RY    = 5'd7;
  localparam logic [4:0] S_EXEC  = 5'd8;
  localparam logic [4:0] S_WX    = 5'd9;
  localparam logic [4:0] S_WF    = 5'd10;
  localparam logic [4:0] S_BCD   = 5'd11;
  localparam logic [4:0] S_S55R  = 5'd12;
  localparam logic [4:0] S_S55W  = 5'd13;
  localparam logic [4:0] S_S65R  = 5'd14;
  localparam logic [4:0] S_S65W  = 5'd15;
  localparam logic [4:0] S_DRR   = 5'd16;
  localparam logic [4:0] S_DRW   = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  logic [4:0]          state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [INDEX_W-1:0]  i_q, i_d;
  logic [SPW-1:0]      sp_q, sp_d;
  logic [7:0]          dt_q, dt_d, st_q, st_d;
  logic [15:0]         op_q, op_d;
  logic [7:0]          vx_q, vx_d;
  logic [7:0]          res_q, res_d;
  logic                f_q, f_d, wf_q, wf_d, hit_q, hit_d;
  logic [XW-1:0]       sx_q, sx_d;
  logic [HW-1:0]       sy_q, sy_d;
  logic [KEYS_W-1:0]   keys_q, keys_d;
  logic [7:0]          rnd_q, rnd_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic                wait_q, wait_d;
  logic [ROW_W-1:0]    rd_q, rd_d;

  // output register
  logic                ovalid_q, ovalid_d;
  logic [PC_W-1:0]     opc_q, opc_d;
  logic [ROW_W-1:0]    ord_q, ord_d;
  logic [STATUS_W-1:0] ostat_q, ostat_d;
  logic                osnd_q, osnd_d, owait_q, owait_d;

  // stack and screen live in flops
  logic [PC_W-1:0] stack_q [STACK_DEPTH];
  logic [SW-1:0]   frame_q [SCREEN_HEIGHT];
  logic            stack_we;
  logic            frame_clr, frame_we;
  logic [HW-1:0]   frame_row;
  logic [SW-1:0]   frame_wdata;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          v_we;
  logic [VIDX_W-1:0] v_waddr, v_raddr;
  logic [7:0]    v_wdata, v_rdata;

  chip8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  chip8_ram #(.WIDTH(8), .DEPTH(NREGS)) u_vregs (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // opcode fields
  logic [3:0]       nib, ox, on;
  logic [7:0]       nn, vy;
  logic [PC_W-1:0]  nnn, pc_p2;
  logic [AW-1:0]    addr_ic;
  logic [SPI-1:0]   sp_top;
  logic [8:0]       sum9;
  logic [1:0]       bcd_h;
  logic [7:0]       bcd_rem, bcd_h100;
  logic [14:0]      bcd_prod;
  logic [3:0]       bcd_t, bcd_o;
  logic [SW+7:0]    spr_ext;
  logic [SW-1:0]    spr_mask;
  logic [HW:0]      py;
  logic             in_font;

  assign nib   = op_q[15:12];
  assign ox    = op_q[11:8];
  assign on    = op_q[3:0];
  assign nn    = op_q[7:0];
  assign nnn   = op_q[11:0];
  assign vy    = v_rdata;
  assign pc_p2 = pc_q + PC_W'(2);
  assign addr_ic = AW'(i_q + INDEX_W'(cnt_q[3:0]));
  assign sp_top  = SPI'(sp_q - SPW'(1));
  assign sum9    = {1'b0, vx_q} + {1'b0, vy};

  // bcd digits by compare and reciprocal multiply
  always_comb begin
    bcd_h    = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
    bcd_h100 = (bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0);
    bcd_rem  = vx_q - bcd_h100;
    bcd_prod = 15'(bcd_rem[6:0]) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - 8'(bcd_t) * 8'd10);
  end

  // sprite byte placed at x = sx, pixels past the edge fall off
  assign spr_ext  = {mem_rdata, {SW{1'b0}}} >> sx_q;
  assign spr_mask = spr_ext[SW+7:8];
  assign py       = (HW+1)'(sy_q) + (HW+1)'(cnt_q[3:0]);
  assign in_font  = (cnt_q >= AW'(FONT_BASE)) && (cnt_q < AW'(FONT_BASE + FONT_BYTES));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  pc_d = pc_q;  i_d = i_q;
    sp_d = sp_q;  dt_d = dt_q;  st_d = st_q;  op_d = op_q;  vx_d = vx_q;
    res_d = res_q;  f_d = f_q;  wf_d = wf_q;  hit_d = hit_q;
    sx_d = sx_q;  sy_d = sy_q;  keys_d = keys_q;  rnd_d = rnd_q;
    stat_d = stat_q;  wait_d = wait_q;  rd_d = rd_q;
    ovalid_d = ovalid_q;  opc_d = opc_q;  ord_d = ord_q;
    ostat_d = ostat_q;  osnd_d = osnd_q;  owait_d = owait_q;
    mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;
    v_we = 1'b0;  v_waddr = '0;  v_wdata = '0;  v_raddr = '0;
    stack_we = 1'b0;  frame_clr = 1'b0;  frame_we = 1'b0;
    frame_row = py[HW-1:0];
    frame_wdata = frame_q[py[HW-1:0]] ^ spr_mask;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = in_font ? font_byte(7'(cnt_q - AW'(FONT_BASE))) : 8'h00;
        v_we      = (cnt_q < AW'(NREGS));
        v_waddr   = cnt_q[VIDX_W-1:0];
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(MEM_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = AW'(address_i);
        if (in_valid_i) begin
          keys_d = keys_i;
          rnd_d  = random_byte_i;
          stat_d = STAT_OK;
          wait_d = 1'b0;
          rd_d   = '0;
          state_d = S_DONE;
          case (cmd_i)
            CMD_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(address_i);
              mem_wdata = data_i;
            end
            CMD_EXEC: state_d = S_F1;
            CMD_TICK: begin
              if (dt_q != 8'd0) dt_d = dt_q - 8'd1;
              if (st_q != 8'd0) st_d = st_q - 8'd1;
            end
            CMD_READ: state_d = S_MRD;
            CMD_ROW:  rd_d = frame_q[address_i[HW-1:0]][SW-1 -: ROW_W];
            default: ;
          endcase
        end
      end
      S_MRD: begin
        rd_d    = ROW_W'(mem_rdata);
        state_d = S_DONE;
      end
      S_F1: begin
        mem_raddr = AW'(pc_q);
        state_d   = S_F2;
      end
      S_F2: begin
        mem_raddr = AW'(pc_q) + AW'(1);
        op_d[15:8] = mem_rdata;
        state_d   = S_F3;
      end
      S_F3: begin
        op_d[7:0] = mem_rdata;
        pc_d      = pc_p2;
        state_d   = S_RX;
      end
      S_RX: begin
        // BNNN adds V0, so read it in place of Vx
        v_raddr = (nib == 4'hB) ? 4'h0 : ox;
        state_d = S_RY;
      end
      S_RY: begin
        vx_d    = v_rdata;
        v_raddr = op_q[7:4];
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        wf_d    = 1'b0;
        case (nib)
          4'h0: begin
            if (nn == NN_CLS) begin
              frame_clr = 1'b1;
            end else if (nn == NN_RET) begin
              if (sp_q == '0) begin
                stat_d = STAT_UNDER;
              end else begin
                sp_d = sp_q - SPW'(1);
                pc_d = stack_q[sp_top];
              end
            end else begin
              stat_d = STAT_BADOP;
            end
          end
          4'h1: pc_d = nnn;
          4'h2: begin
            if (sp_q >= SPW'(STACK_DEPTH)) begin
              stat_d = STAT_OVER;
            end else begin
              stack_we = 1'b1;
              sp_d     = sp_q + SPW'(1);
              pc_d     = nnn;
            end
          end
          4'h3: if (vx_q == nn) pc_d = pc_p2;
          4'h4: if (vx_q != nn) pc_d = pc_p2;
          4'h5: begin
            if (on != 4'h0) stat_d = STAT_BADOP;
            else if (vx_q == vy) pc_d = pc_p2;
          end
          4'h6: begin res_d = nn; state_d = S_WX; end
          4'h7: begin res_d = vx_q + nn; state_d = S_WX; end
          4'h8: begin
            state_d = S_WX;
            wf_d    = 1'b1;
            case (on)
              4'h0: begin res_d = vy; wf_d = 1'b0; end
              4'h1: begin res_d = vx_q | vy; wf_d = 1'b0; end
              4'h2: begin res_d = vx_q & vy; wf_d = 1'b0; end
              4'h3: begin res_d = vx_q ^ vy; wf_d = 1'b0; end
              4'h4: begin res_d = sum9[7:0]; f_d = sum9[8]; end
              4'h5: begin res_d = vx_q - vy; f_d = (vx_q >= vy); end
              4'h6: begin res_d = {1'b0, vx_q[7:1]}; f_d = vx_q[0]; end
              4'h7: begin res_d = vy - vx_q; f_d = (vy >= vx_q); end
              4'hE: begin res_d = {vx_q[6:0], 1'b0}; f_d = vx_q[7]; end
              default: begin
                stat_d  = STAT_BADOP;
                wf_d    = 1'b0;
                state_d = S_DONE;
              end
            endcase
          end
          4'h9: if (on == 4'h0 && vx_q != vy) pc_d = pc_p2;
          4'hA: i_d = INDEX_W'(nnn);
          4'hB: pc_d = nnn + PC_W'(vx_q);
          4'hC: begin res_d = rnd_q & nn; state_d = S_WX; end
          4'hD: begin
            sx_d  = vx_q[XW-1:0];
            sy_d  = vy[HW-1:0];
            cnt_d = '0;
            hit_d = 1'b0;
            state_d = S_DRR;
          end
          4'hE: begin
            if (nn == NN_SKP) begin
              if (vx_q[7:4] == 4'h0 && keys_q[vx_q[3:0]]) pc_d = pc_p2;
            end else if (nn == NN_SKNP) begin
              if (!(vx_q[7:4] == 4'h0 && keys_q[vx_q[3:0]])) pc_d = pc_p2;
            end else begin
              stat_d = STAT_BADOP;
            end
          end
          default: begin
            cnt_d = '0;
            case (nn)
              NN_GDT: begin res_d = dt_q; state_d = S_WX; end
              NN_KEY: begin
                if (keys_q != '0) begin
                  res_d   = 8'(lowest_key(keys_q));
                  state_d = S_WX;
                end else begin
                  pc_d   = pc_q - PC_W'(2);
                  wait_d = 1'b1;
                end
              end
              NN_SDT:  dt_d = vx_q;
              NN_SST:  st_d = vx_q;
              NN_ADDI: i_d = i_q + INDEX_W'(vx_q);
              NN_FONT: i_d = INDEX_W'(FONT_BASE) + INDEX_W'({vx_q, 2'b00})
                             + INDEX_W'(vx_q);
              NN_BCD:  state_d = S_BCD;
              NN_STR:  state_d = S_S55R;
              NN_LDR:  state_d = S_S65R;
              default: stat_d = STAT_BADOP;
            endcase
          end
        endcase
      end
      S_WX: begin
        v_we    = 1'b1;
        v_waddr = ox;
        v_wdata = res_q;
        state_d = wf_q ? S_WF : S_DONE;
      end
      S_WF: begin
        // flag register goes last so it wins when x is F
        v_we    = 1'b1;
        v_waddr = VF_IDX;
        v_wdata = {7'd0, f_q};
        state_d = S_DONE;
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = addr_ic;
        case (cnt_q[1:0])
          2'd0:    mem_wdata = {6'd0, bcd_h};
          2'd1:    mem_wdata = {4'd0, bcd_t};
          default: mem_wdata = {4'd0, bcd_o};
        endcase
        cnt_d = cnt_q + AW'(1);
        if (cnt_q[1:0] == 2'd2) state_d = S_DONE;
      end
      S_S55R: begin
        v_raddr = cnt_q[VIDX_W-1:0];
        state_d = S_S55W;
      end
      S_S55W: begin
        mem_we    = 1'b1;
        mem_waddr = addr_ic;
        mem_wdata = v_rdata;
        cnt_d     = cnt_q + AW'(1);
        state_d   = (cnt_q[VIDX_W-1:0] == ox) ? S_DONE : S_S55R;
      end
      S_S65R: begin
        mem_raddr = addr_ic;
        state_d   = S_S65W;
      end
      S_S65W: begin
        v_we    = 1'b1;
        v_waddr = cnt_q[VIDX_W-1:0];
        v_wdata = mem_rdata;
        cnt_d   = cnt_q + AW'(1);
        state_d = (cnt_q[VIDX_W-1:0] == ox) ? S_DONE : S_S65R;
      end
      S_DRR: begin
        mem_raddr = addr_ic;
        if (cnt_q == AW'(on)) begin
          f_d     = hit_q;
          state_d = S_WF;
        end else begin
          state_d = S_DRW;
        end
      end
      S_DRW: begin
        if (py < (HW+1)'(SCREEN_HEIGHT)) begin
          frame_we = 1'b1;
          if ((frame_q[py[HW-1:0]] & spr_mask) != '0) hit_d = 1'b1;
        end
        cnt_d   = cnt_q + AW'(1);
        state_d = S_DRR;
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          opc_d    = pc_q;
          ord_d    = rd_q;
          ostat_d  = stat_q;
          osnd_d   = (st_q != 8'd0);
          owait_d  = wait_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      pc_q     <= PC_W'(PROGRAM_START);
      i_q      <= '0;
      sp_q     <= '0;
      dt_q     <= '0;
      st_q     <= '0;
      ovalid_q <= 1'b0;
      for (int r = 0; r < int'(SCREEN_HEIGHT); r++) frame_q[r] <= '0;
      for (int s = 0; s < int'(STACK_DEPTH); s++) stack_q[s] <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pc_q     <= pc_d;
      i_q      <= i_d;
      sp_q     <= sp_d;
      dt_q     <= dt_d;
      st_q     <= st_d;
      ovalid_q <= ovalid_d;
      if (stack_we) stack_q[sp_q[SPI-1:0]] <= pc_q;
      if (frame_clr) begin
        for (int r = 0; r < int'(SCREEN_HEIGHT); r++) frame_q[r] <= '0;
      end else if (frame_we) begin
        frame_q[frame_row] <= frame_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;   vx_q   <= vx_d;   res_q  <= res_d;
    f_q    <= f_d;    wf_q   <= wf_d;   hit_q  <= hit_d;
    sx_q   <= sx_d;   sy_q   <= sy_d;
    keys_q <= keys_d; rnd_q  <= rnd_d;  stat_q <= stat_d;
    wait_q <= wait_d; rd_q   <= rd_d;
    opc_q  <= opc_d;  ord_q  <= ord_d;  ostat_q <= ostat_d;
    osnd_q <= osnd_d; owait_q <= owait_d;
  end

  assign out_valid_o       = ovalid_q;
  assign program_counter_o = opc_q;
  assign read_data_o       = ord_q;
  assign status_o          = ostat_q;
  assign sound_on_o        = osnd_q;
  assign waiting_key_o     = owait_q;

  // stack pointer never runs past the stack
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer out of range");

  // one item at a time: after an accept the core is busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // no items during the memory clearing pass
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o && !out_valid_o)
    else $error("handshake during clearing pass");

  // a result is loaded only once the previous one has left
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && ovalid_q && !out_ready_i |=> state_q == S_DONE)
    else $error("result overwritten");

endmodule

[src/chip8_ram.sv]
// ----------------------------------------------------------------------------
// chip8_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module chip8_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
